[hw/rtl/i2cm_pkg.sv]
`default_nettype none

package i2cm_pkg;

  localparam int unsigned CfgW    = 20;
  localparam int unsigned HalfW   = 16;
  localparam int unsigned TmoW    = 8;
  localparam int unsigned AddrW   = 7;
  localparam int unsigned TickW   = 20;
  localparam int unsigned MeasW   = 32;

  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  localparam logic [1:0] CFG_HALF_PERIOD  = 2'd0;
  localparam logic [1:0] CFG_ACK_TIMEOUT  = 2'd1;
  localparam logic [1:0] CFG_DEVICE_ADDR  = 2'd2;
  localparam logic [1:0] CFG_WRITE_SETTLE = 2'd3;

  localparam logic [HalfW-1:0] HALF_PERIOD_RST  = 16'd20;
  localparam logic [TmoW-1:0]  ACK_TIMEOUT_RST  = 8'd250;
  localparam logic [AddrW-1:0] DEVICE_ADDR_RST  = 7'd88;
  localparam logic [TickW-1:0] WRITE_SETTLE_RST = 20'd100000;

  // Byte positions of a read: the third byte carries the CRC
  localparam logic [2:0] BYTE_CRC       = 3'd2;
  localparam logic [2:0] BYTE_LAST_ACK  = 3'd4;
  localparam logic [2:0] BYTES_PER_READ = 3'd5;
  localparam logic [2:0] BYTES_PER_WRITE = 3'd3;
  localparam logic [3:0] BITS_PER_BYTE  = 4'd8;

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_START_A,
    PH_START_B,
    PH_TX_LO,
    PH_TX_HI,
    PH_ACK_LO,
    PH_ACK_HI,
    PH_RX_LO,
    PH_RX_HI,
    PH_MACK_LO,
    PH_MACK_HI,
    PH_STOP_A,
    PH_STOP_B,
    PH_STOP_C,
    PH_SETTLE
  } phase_e;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] cmd_byte_hi;
    logic [7:0] cmd_byte_lo;
    logic       sda_in;
  } in_item_t;

  typedef struct packed {
    logic             scl;
    logic             sda_drive_low;
    logic             busy_res;
    logic             done_res;
    logic             ack_error;
    logic [MeasW-1:0] measurement;
  } out_item_t;

endpackage

`default_nettype wire

[hw/rtl/i2cm_if.sv]
`default_nettype none

interface i2cm_in_if import i2cm_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface i2cm_out_if import i2cm_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

[hw/rtl/i2c_sensor_command_master.sv]
`default_nettype none

// Channel   Dir  Payload                                           Role
// cmd_i     in   command, cmd_byte_hi, cmd_byte_lo, sda_in         one timing tick
// res_o     out  scl, sda_drive_low, busy_res, done_res,           line levels and
//                ack_error, measurement                            status for the tick
// cfg_*     in   cfg_idx_i, cfg_wdata_i under cfg_we_i             register writes
//
// One tick is taken every cycle; its result appears in the output register on
// the following cycle. Between input and result register lie the bus sequencer's
// next-phase logic (a 20-bit increment and compare) and the line-level decode.
// A tick is taken while the output register is empty or being emptied, so a
// stalled sink holds back only one tick. Reset at once clears all state except
// the result payload and loads the register defaults; there is no start-up sweep.

module i2c_sensor_command_master import i2cm_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  i2cm_in_if.sink           cmd_i,
  i2cm_out_if.source        res_o,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_idx_i,
  input  logic [CfgW-1:0]   cfg_wdata_i
);

  // Configuration registers
  logic [HalfW-1:0] half_q;
  logic [TmoW-1:0]  tmo_q;
  logic [AddrW-1:0] addr_q;
  logic [TickW-1:0] settle_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_q   <= HALF_PERIOD_RST;
      tmo_q    <= ACK_TIMEOUT_RST;
      addr_q   <= DEVICE_ADDR_RST;
      settle_q <= WRITE_SETTLE_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_HALF_PERIOD:  half_q   <= cfg_wdata_i[HalfW-1:0];
        CFG_ACK_TIMEOUT:  tmo_q    <= cfg_wdata_i[TmoW-1:0];
        CFG_DEVICE_ADDR:  addr_q   <= cfg_wdata_i[AddrW-1:0];
        CFG_WRITE_SETTLE: settle_q <= cfg_wdata_i[TickW-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer state
  phase_e           phase_q, phase_d;
  logic [TickW-1:0] tick_q, tick_d;
  logic [3:0]       bit_q, bit_d;
  logic [2:0]       byte_q, byte_d;
  logic [7:0]       shift_q, shift_d;
  logic [MeasW-1:0] accum_q, accum_d;
  logic             rd_q, rd_d;
  logic             err_q, err_d;
  logic [15:0]      hold_q, hold_d;
  logic [MeasW-1:0] meas_q, meas_d;

  out_item_t        res_q;
  out_item_t        res_d;
  logic             res_valid_q;

  logic             in_acc;
  logic             cmd_start;
  phase_e           ph_cur;
  logic [TickW-1:0] tick_cur;
  logic [TickW-1:0] tick_inc;
  logic [HalfW-1:0] half_eff;
  logic             seg_over;
  logic             settle_over;
  logic [3:0]       bit_inc;
  logic [2:0]       byte_inc;
  logic             finish;
  logic             scl;
  logic             sdl;

  assign cmd_i.ready = !res_valid_q || res_o.ready;
  assign in_acc      = cmd_i.valid && cmd_i.ready;

  assign cmd_start = (phase_q == PH_IDLE) &&
                     (cmd_i.data.command == CMD_WRITE || cmd_i.data.command == CMD_READ);
  assign ph_cur    = cmd_start ? PH_START_A : phase_q;
  assign tick_cur  = cmd_start ? '0 : tick_q;

  assign half_eff    = (half_q == '0) ? HalfW'(1) : half_q;
  assign tick_inc    = tick_cur + TickW'(1);
  assign seg_over    = tick_inc >= {{(TickW-HalfW){1'b0}}, half_eff};
  assign settle_over = tick_inc >= settle_q;
  assign bit_inc     = bit_q + 4'd1;
  assign byte_inc    = byte_q + 3'd1;

  // Next phase and datapath
  always_comb begin
    phase_d = ph_cur;
    tick_d  = tick_cur;
    bit_d   = cmd_start ? 4'd0 : bit_q;
    byte_d  = cmd_start ? 3'd0 : byte_q;
    shift_d = cmd_start ? {addr_q, (cmd_i.data.command == CMD_READ)} : shift_q;
    accum_d = cmd_start ? '0 : accum_q;
    rd_d    = cmd_start ? (cmd_i.data.command == CMD_READ) : rd_q;
    err_d   = cmd_start ? 1'b0 : err_q;
    hold_d  = cmd_start ? {cmd_i.data.cmd_byte_hi, cmd_i.data.cmd_byte_lo} : hold_q;
    meas_d  = meas_q;
    finish  = 1'b0;

    case (ph_cur)
      PH_START_A, PH_TX_LO, PH_ACK_LO, PH_RX_LO, PH_MACK_LO, PH_STOP_A, PH_STOP_B: begin
        tick_d = seg_over ? '0 : tick_inc;
        if (seg_over) begin
          case (ph_cur)
            PH_START_A: phase_d = PH_START_B;
            PH_TX_LO:   phase_d = PH_TX_HI;
            PH_ACK_LO:  phase_d = PH_ACK_HI;
            PH_RX_LO:   phase_d = PH_RX_HI;
            PH_MACK_LO: phase_d = PH_MACK_HI;
            PH_STOP_A:  phase_d = PH_STOP_B;
            default:    phase_d = PH_STOP_C;
          endcase
        end
      end
      PH_START_B: begin
        tick_d = seg_over ? '0 : tick_inc;
        if (seg_over) begin
          bit_d   = 4'd0;
          phase_d = PH_TX_LO;
        end
      end
      PH_TX_HI: begin
        tick_d = seg_over ? '0 : tick_inc;
        if (seg_over) begin
          shift_d = {shift_q[6:0], 1'b0};
          bit_d   = bit_inc;
          phase_d = (bit_inc >= BITS_PER_BYTE) ? PH_ACK_LO : PH_TX_LO;
        end
      end
      PH_ACK_HI: begin
        if (!cmd_i.data.sda_in) begin
          tick_d = '0;
          bit_d  = 4'd0;
          byte_d = byte_inc;
          if (rd_q) begin
            byte_d  = 3'd0;
            shift_d = 8'd0;
            phase_d = PH_RX_LO;
          end else if (byte_inc >= BYTES_PER_WRITE) begin
            phase_d = PH_STOP_A;
          end else begin
            shift_d = (byte_inc == 3'd1) ? hold_q[15:8] : hold_q[7:0];
            phase_d = PH_TX_LO;
          end
        end else begin
          tick_d = tick_inc;
          // abort once the high samples exceed the tolerated count
          if (tick_inc > {{(TickW-TmoW){1'b0}}, tmo_q}) begin
            tick_d  = '0;
            err_d   = 1'b1;
            phase_d = PH_STOP_A;
          end
        end
      end
      PH_RX_HI: begin
        if (tick_cur == '0) begin
          shift_d = {shift_q[6:0], cmd_i.data.sda_in};
        end
        tick_d = seg_over ? '0 : tick_inc;
        if (seg_over) begin
          bit_d   = bit_inc;
          phase_d = (bit_inc >= BITS_PER_BYTE) ? PH_MACK_LO : PH_RX_LO;
        end
      end
      PH_MACK_HI: begin
        tick_d = seg_over ? '0 : tick_inc;
        if (seg_over) begin
          if (byte_q != BYTE_CRC) begin
            accum_d = {accum_q[MeasW-9:0], shift_q};
          end
          byte_d  = byte_inc;
          bit_d   = 4'd0;
          shift_d = 8'd0;
          phase_d = (byte_inc >= BYTES_PER_READ) ? PH_STOP_A : PH_RX_LO;
        end
      end
      PH_STOP_C: begin
        tick_d = seg_over ? '0 : tick_inc;
        if (seg_over) begin
          if (!rd_q && !err_q && settle_q != '0) begin
            phase_d = PH_SETTLE;
          end else begin
            finish = 1'b1;
          end
        end
      end
      PH_SETTLE: begin
        tick_d = settle_over ? '0 : tick_inc;
        finish = settle_over;
      end
      default: begin
        phase_d = PH_IDLE;
      end
    endcase

    if (finish) begin
      if (rd_q && !err_q) begin
        meas_d = accum_q;
      end
      phase_d = PH_IDLE;
      tick_d  = '0;
    end
  end

  // Line levels for the tick
  always_comb begin
    scl = 1'b1;
    sdl = 1'b0;
    case (ph_cur)
      PH_START_B:               sdl = 1'b1;
      PH_TX_LO: begin
        scl = 1'b0;
        sdl = !shift_q[7];
      end
      PH_TX_HI:                 sdl = !shift_q[7];
      PH_ACK_LO, PH_RX_LO:      scl = 1'b0;
      PH_MACK_LO: begin
        scl = 1'b0;
        sdl = byte_q < BYTE_LAST_ACK;
      end
      PH_MACK_HI:               sdl = byte_q < BYTE_LAST_ACK;
      PH_STOP_A: begin
        scl = 1'b0;
        sdl = 1'b1;
      end
      PH_STOP_B:                sdl = 1'b1;
      default: ;
    endcase
  end

  always_comb begin
    res_d.scl           = scl;
    res_d.sda_drive_low = sdl;
    res_d.busy_res      = (ph_cur != PH_IDLE);
    res_d.done_res      = finish;
    res_d.ack_error     = err_d;
    res_d.measurement   = meas_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      tick_q  <= '0;
      bit_q   <= '0;
      byte_q  <= '0;
      shift_q <= '0;
      accum_q <= '0;
      rd_q    <= 1'b0;
      err_q   <= 1'b0;
      hold_q  <= '0;
      meas_q  <= '0;
    end else if (in_acc) begin
      phase_q <= phase_d;
      tick_q  <= tick_d;
      bit_q   <= bit_d;
      byte_q  <= byte_d;
      shift_q <= shift_d;
      accum_q <= accum_d;
      rd_q    <= rd_d;
      err_q   <= err_d;
      hold_q  <= hold_d;
      meas_q  <= meas_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (cmd_i.ready) begin
      res_valid_q <= cmd_i.valid;
    end
  end

  // hold the payload while the sink stalls
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      res_q <= res_d;
    end
  end

  assign res_o.valid = res_valid_q;
  assign res_o.data  = res_q;

  a_start_levels: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && cmd_start) |=>
      (res_q.busy_res && res_q.scl && !res_q.sda_drive_low && !res_q.ack_error &&
       !res_q.done_res))
    else $error("first tick of a transaction has wrong line levels");

  a_idle_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && phase_q == PH_IDLE && !cmd_start) |=>
      (res_q.scl && !res_q.sda_drive_low && !res_q.busy_res && !res_q.done_res))
    else $error("idle tick drives the bus");

  a_meas_on_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (res_q.measurement == $past(meas_q) || res_q.done_res))
    else $error("measurement changed outside the end of a transaction");

  a_bit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (bit_q <= BITS_PER_BYTE) && (byte_q <= BYTES_PER_READ))
    else $error("bit or byte counter out of range");

endmodule

`default_nettype wire
